>>> src/jmsp_pkg.sv
// Package with the types and constants shared by the JPEG marker stream probe.
package jmsp_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_NOTJPEG = 3'd1,
    VERDICT_PROG    = 3'd2,
    VERDICT_UNSUP   = 3'd3,
    VERDICT_TRUNC   = 3'd4
  } verdict_t;

  typedef enum logic [7:0] {
    PH_SOI0 = 8'b0000_0001,
    PH_SOI1 = 8'b0000_0010,
    PH_MARK = 8'b0000_0100,
    PH_FILL = 8'b0000_1000,
    PH_LENH = 8'b0001_0000,
    PH_LENL = 8'b0010_0000,
    PH_SKIP = 8'b0100_0000,
    PH_SCAN = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic     valid;
    verdict_t verdict;
  } result_t;

  localparam logic [7:0] BYTE_FILL   = 8'hFF;
  localparam logic [7:0] BYTE_SOI    = 8'hD8;
  localparam logic [7:0] BYTE_EOI    = 8'hD9;
  localparam logic [7:0] BYTE_SOS    = 8'hDA;
  localparam logic [7:0] BYTE_PROG   = 8'hC2;
  localparam logic [7:0] BYTE_SOF3   = 8'hC3;
  localparam logic [7:0] BYTE_SOF5   = 8'hC5;
  localparam logic [7:0] BYTE_SOF7   = 8'hC7;
  localparam logic [7:0] BYTE_SOF9   = 8'hC9;
  localparam logic [7:0] BYTE_SOF15  = 8'hCF;
  localparam logic [7:0] BYTE_TEM    = 8'h01;
  localparam logic [7:0] BYTE_RST0   = 8'hD0;
  localparam logic [7:0] BYTE_RST7   = 8'hD7;
  localparam logic [7:0] EOI_WINDOW_RESET = 8'd64;
  localparam logic [2:0] COUNT_SAT   = 3'd7;
  localparam logic [2:0] COUNT_MIN   = 3'd4;
  localparam logic [2:0] PAIR_START  = 3'd2;
  localparam logic [7:0] AGE_SAT     = 8'd255;

endpackage

>>> src/jmsp_if.sv
// Handshake interfaces for the byte input, verdict output and window configuration channels.
interface jmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface jmsp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

interface jmsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/jmsp_parser.sv
// Marker segment walker, end-of-image pair tracker and verdict logic for one byte a cycle while accept is high.
module jmsp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  input  logic [7:0]         eoi_window,
  output jmsp_pkg::result_t  result
);

  jmsp_pkg::phase_t   phase_r, phase_nxt;
  jmsp_pkg::verdict_t latched_r, latched_nxt;
  logic               vv_r, vv_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [7:0]         len_high_r, len_high_nxt;
  logic [2:0]         count_r, count_nxt;
  logic               sos_r, sos_nxt;
  logic               prev_ff_r, prev_ff_nxt;
  logic               pair_seen_r, pair_seen_nxt;
  logic [7:0]         pair_age_r, pair_age_nxt;
  logic [15:0]        seglen;
  logic [15:0]        skip_dec;
  jmsp_pkg::verdict_t verdict;

  assign seglen   = {len_high_r, data_byte};
  assign skip_dec = (skip_r != 16'd0) ? skip_r - 16'd1 : skip_r;

  always_comb begin
    phase_nxt     = phase_r;
    latched_nxt   = latched_r;
    vv_nxt        = vv_r;
    skip_nxt      = skip_r;
    len_high_nxt  = len_high_r;
    sos_nxt       = sos_r;
    count_nxt     = (count_r < jmsp_pkg::COUNT_SAT) ? count_r + 3'd1 : count_r;
    pair_seen_nxt = pair_seen_r;
    pair_age_nxt  = (pair_seen_r && pair_age_r < jmsp_pkg::AGE_SAT) ? pair_age_r + 8'd1
                                                                     : pair_age_r;
    if (prev_ff_r && data_byte == jmsp_pkg::BYTE_EOI) begin
      pair_seen_nxt = 1'b1;
      pair_age_nxt  = 8'd1;
    end
    // The count before this byte is its position in the file, saturating at 7.
    prev_ff_nxt = (count_r >= jmsp_pkg::PAIR_START) && (data_byte == jmsp_pkg::BYTE_FILL);

    if (!vv_r) begin
      if (is_last && phase_r == jmsp_pkg::PH_MARK) begin
        vv_nxt      = 1'b1;
        latched_nxt = jmsp_pkg::VERDICT_TRUNC;
      end else begin
        case (phase_r)
          jmsp_pkg::PH_SOI0: begin
            if (data_byte != jmsp_pkg::BYTE_FILL) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_NOTJPEG;
            end else begin
              phase_nxt = jmsp_pkg::PH_SOI1;
            end
          end
          jmsp_pkg::PH_SOI1: begin
            if (data_byte != jmsp_pkg::BYTE_SOI) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_NOTJPEG;
            end else begin
              phase_nxt = jmsp_pkg::PH_MARK;
            end
          end
          jmsp_pkg::PH_MARK: begin
            if (data_byte != jmsp_pkg::BYTE_FILL) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_NOTJPEG;
            end else begin
              phase_nxt = jmsp_pkg::PH_FILL;
            end
          end
          jmsp_pkg::PH_FILL: begin
            if (data_byte == jmsp_pkg::BYTE_FILL) begin
              phase_nxt = jmsp_pkg::PH_FILL;
            end else if (data_byte == jmsp_pkg::BYTE_SOI || data_byte == jmsp_pkg::BYTE_TEM ||
                         data_byte inside {[jmsp_pkg::BYTE_RST0:jmsp_pkg::BYTE_RST7]}) begin
              phase_nxt = jmsp_pkg::PH_MARK;
            end else if (data_byte == jmsp_pkg::BYTE_EOI) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_TRUNC;
            end else if (data_byte == jmsp_pkg::BYTE_SOS) begin
              sos_nxt   = 1'b1;
              phase_nxt = jmsp_pkg::PH_SCAN;
            end else if (data_byte == jmsp_pkg::BYTE_PROG) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_PROG;
            end else if (data_byte inside {jmsp_pkg::BYTE_SOF3,
                                           [jmsp_pkg::BYTE_SOF5:jmsp_pkg::BYTE_SOF7],
                                           [jmsp_pkg::BYTE_SOF9:jmsp_pkg::BYTE_SOF15]}) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_UNSUP;
            end else begin
              phase_nxt = jmsp_pkg::PH_LENH;
            end
          end
          jmsp_pkg::PH_LENH: begin
            len_high_nxt = data_byte;
            phase_nxt    = jmsp_pkg::PH_LENL;
          end
          jmsp_pkg::PH_LENL: begin
            if (seglen < 16'd2) begin
              vv_nxt      = 1'b1;
              latched_nxt = jmsp_pkg::VERDICT_NOTJPEG;
            end else begin
              skip_nxt  = seglen - 16'd2;
              phase_nxt = (seglen != 16'd2) ? jmsp_pkg::PH_SKIP : jmsp_pkg::PH_MARK;
            end
          end
          jmsp_pkg::PH_SKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = jmsp_pkg::PH_MARK;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    if (count_nxt < jmsp_pkg::COUNT_MIN) begin
      verdict = jmsp_pkg::VERDICT_NOTJPEG;
    end else if (vv_nxt) begin
      verdict = latched_nxt;
    end else if (!sos_nxt) begin
      verdict = jmsp_pkg::VERDICT_TRUNC;
    end else if (pair_seen_nxt && pair_age_nxt < eoi_window) begin
      verdict = jmsp_pkg::VERDICT_OK;
    end else begin
      verdict = jmsp_pkg::VERDICT_TRUNC;
    end
  end

  assign result = {accept && is_last, verdict};

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && is_last)) begin
      phase_r     <= jmsp_pkg::PH_SOI0;
      latched_r   <= jmsp_pkg::VERDICT_OK;
      vv_r        <= 1'b0;
      skip_r      <= 16'd0;
      len_high_r  <= 8'd0;
      count_r     <= 3'd0;
      sos_r       <= 1'b0;
      prev_ff_r   <= 1'b0;
      pair_seen_r <= 1'b0;
      pair_age_r  <= 8'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      latched_r   <= latched_nxt;
      vv_r        <= vv_nxt;
      skip_r      <= skip_nxt;
      len_high_r  <= len_high_nxt;
      count_r     <= count_nxt;
      sos_r       <= sos_nxt;
      prev_ff_r   <= prev_ff_nxt;
      pair_seen_r <= pair_seen_nxt;
      pair_age_r  <= pair_age_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("parse phase is not one-hot");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> count_r == 3'd0 && !vv_r && !sos_r && !pair_seen_r)
    else $error("stream state not cleared after the final byte");
  a_verdict_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_last && vv_r |=> vv_r && latched_r == $past(latched_r))
    else $error("latched verdict changed within a file");
  a_scan_has_sos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == jmsp_pkg::PH_SCAN |-> sos_r)
    else $error("scan phase entered without SOS");
`endif

endmodule

>>> src/jmsp_out_reg.sv
// Result register that holds the verdict until the sink takes it.
module jmsp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  jmsp_pkg::result_t   result,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_verdict,
  output logic                can_take
);

  logic       valid_r, valid_nxt;
  logic [2:0] verdict_r;

  // A new word may enter when none is held or when the held one leaves in the same cycle.
  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = result.valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      verdict_r <= result.verdict;
    end
  end

  assign out_valid   = valid_r;
  assign out_verdict = verdict_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> can_take)
    else $error("verdict produced while the held word is stalled");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |=> valid_r && verdict_r == $past(result.verdict))
    else $error("verdict not loaded into the result register");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !result.valid && valid_r && out_ready |=> !valid_r)
    else $error("result word not released after being taken");
`endif

endmodule

>>> src/jpeg_marker_stream_probe.sv
// Top level of the JPEG marker stream probe: channels, window register and submodules.
// Takes a JPEG file one byte per clock cycle (is_last marks the final byte) and returns
// one verdict word per file: 0 ok baseline, 1 not JPEG, 2 progressive, 3 unsupported
// variant, 4 truncated. Every byte is handled in the cycle it is accepted, so the input
// sustains one byte per cycle; the verdict enters the result register in the cycle after
// the final byte is accepted. Input ready drops only while a verdict word waits in the
// result register and the sink is not taking it. The end-of-image search window is one
// 8-bit register (reset 64), written through the configuration channel, which is always
// ready; write it only between files.
module jpeg_marker_stream_probe (
  input  logic              clk,
  input  logic              rst_n,
  jmsp_in_if.sink           in_ch,
  jmsp_out_if.source        out_ch,
  jmsp_cfg_if.sink          cfg_ch
);

  logic              in_accept;
  logic              can_take;
  logic [7:0]        eoi_window_r;
  jmsp_pkg::result_t result;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_take;
  assign in_accept    = in_ch.valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eoi_window_r <= jmsp_pkg::EOI_WINDOW_RESET;
    end else if (cfg_ch.valid) begin
      eoi_window_r <= cfg_ch.data;
    end
  end

  jmsp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_ch.data_byte),
    .is_last    (in_ch.is_last),
    .eoi_window (eoi_window_r),
    .result     (result)
  );

  jmsp_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .result      (result),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_verdict (out_ch.verdict),
    .can_take    (can_take)
  );

endmodule

>>> sim/jpeg_marker_stream_probe_tb.sv
// Testbench for the JPEG marker stream probe: random and directed files checked against a predictor.
module jpeg_marker_stream_probe_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] MARK_SOF0     = 8'hC0;
  localparam logic [7:0] MARK_SOF1     = 8'hC1;
  localparam logic [7:0] MARK_SOF3     = 8'hC3;
  localparam logic [7:0] MARK_DHT      = 8'hC4;
  localparam logic [7:0] MARK_SOF5     = 8'hC5;
  localparam logic [7:0] MARK_SOF7     = 8'hC7;
  localparam logic [7:0] MARK_SOF9     = 8'hC9;
  localparam logic [7:0] MARK_DAC      = 8'hCC;
  localparam logic [7:0] MARK_SOF15    = 8'hCF;
  localparam logic [7:0] MARK_DQT      = 8'hDB;
  localparam logic [7:0] MARK_DRI      = 8'hDD;
  localparam logic [7:0] MARK_APP0     = 8'hE0;
  localparam logic [7:0] MARK_COM      = 8'hFE;
  localparam logic [7:0] MARK_PLAIN_LO = 8'h02;
  localparam logic [7:0] MARK_PLAIN_HI = 8'hBF;
  localparam logic [7:0] BYTE_STUFF    = 8'h00;
  localparam int         STUCK_LIMIT   = 1000;

  typedef enum {
    FLAW_NONE, FLAW_CUT, FLAW_PROG, FLAW_VARIANT, FLAW_SHORT_LEN,
    FLAW_NO_MARK, FLAW_EARLY_EOI, FLAW_NO_EOI, FLAW_NOISE, FLAW_TINY
  } flaw_t;

  logic clk = 1'b0;
  logic rst_n;

  jmsp_in_if  in_if ();
  jmsp_out_if out_if ();
  jmsp_cfg_if cfg_if ();

  jpeg_marker_stream_probe dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #6 clk = ~clk;

  // Predictor state for the file currently streaming in.
  jmsp_pkg::phase_t   stream_phase;
  jmsp_pkg::verdict_t held_verdict;
  logic               verdict_held;
  logic [15:0]        skip_left;
  logic [7:0]         len_high;
  logic [2:0]         bytes_seen;
  logic               scan_started;
  logic               last_was_ff;
  logic               eoi_pair_seen;
  logic [7:0]         eoi_pair_age;
  logic [7:0]         eoi_window_cfg;

  jmsp_pkg::verdict_t expected_verdicts[$];
  logic [7:0]         file_bytes[$];
  int                 fail_count = 0;
  bit                 idle_enabled = 1'b1;
  int                 rx_hold = 0;
  int                 stuck_cycles = 0;

  function automatic int idle_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_file_state();
    stream_phase  = jmsp_pkg::PH_SOI0;
    held_verdict  = jmsp_pkg::VERDICT_OK;
    verdict_held  = 1'b0;
    skip_left     = '0;
    len_high      = '0;
    bytes_seen    = '0;
    scan_started  = 1'b0;
    last_was_ff   = 1'b0;
    eoi_pair_seen = 1'b0;
    eoi_pair_age  = '0;
  endtask

  task automatic hold_verdict(input jmsp_pkg::verdict_t v);
    held_verdict = v;
    verdict_held = 1'b1;
  endtask

  task automatic walk_markers(input logic [7:0] b);
    logic [15:0] seg_len;
    case (stream_phase)
      jmsp_pkg::PH_SOI0: begin
        if (b != jmsp_pkg::BYTE_FILL) hold_verdict(jmsp_pkg::VERDICT_NOTJPEG);
        else stream_phase = jmsp_pkg::PH_SOI1;
      end
      jmsp_pkg::PH_SOI1: begin
        if (b != jmsp_pkg::BYTE_SOI) hold_verdict(jmsp_pkg::VERDICT_NOTJPEG);
        else stream_phase = jmsp_pkg::PH_MARK;
      end
      jmsp_pkg::PH_MARK: begin
        if (b != jmsp_pkg::BYTE_FILL) hold_verdict(jmsp_pkg::VERDICT_NOTJPEG);
        else stream_phase = jmsp_pkg::PH_FILL;
      end
      jmsp_pkg::PH_FILL: begin
        if (b == jmsp_pkg::BYTE_FILL) begin
          // Fill bytes are simply absorbed.
        end else if (b == jmsp_pkg::BYTE_SOI || b == jmsp_pkg::BYTE_TEM ||
                     (b >= jmsp_pkg::BYTE_RST0 && b <= jmsp_pkg::BYTE_RST7)) begin
          stream_phase = jmsp_pkg::PH_MARK;
        end else if (b == jmsp_pkg::BYTE_EOI) begin
          hold_verdict(jmsp_pkg::VERDICT_TRUNC);
        end else if (b == jmsp_pkg::BYTE_SOS) begin
          scan_started = 1'b1;
          stream_phase = jmsp_pkg::PH_SCAN;
        end else if (b == jmsp_pkg::BYTE_PROG) begin
          hold_verdict(jmsp_pkg::VERDICT_PROG);
        end else if (b == MARK_SOF3 || (b >= MARK_SOF5 && b <= MARK_SOF7) ||
                     (b >= MARK_SOF9 && b <= MARK_SOF15)) begin
          hold_verdict(jmsp_pkg::VERDICT_UNSUP);
        end else begin
          stream_phase = jmsp_pkg::PH_LENH;
        end
      end
      jmsp_pkg::PH_LENH: begin
        len_high = b;
        stream_phase = jmsp_pkg::PH_LENL;
      end
      jmsp_pkg::PH_LENL: begin
        seg_len = {len_high, b};
        if (seg_len < 16'd2) begin
          hold_verdict(jmsp_pkg::VERDICT_NOTJPEG);
        end else begin
          skip_left = seg_len - 16'd2;
          stream_phase = (skip_left != 0) ? jmsp_pkg::PH_SKIP : jmsp_pkg::PH_MARK;
        end
      end
      jmsp_pkg::PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) stream_phase = jmsp_pkg::PH_MARK;
      end
      default: ;
    endcase
  endtask

  // Advances the predictor by one accepted word and queues the verdict on the final byte.
  task automatic predict_byte(input logic [7:0] b, input logic is_final);
    logic [2:0]         pos;
    jmsp_pkg::verdict_t v;
    pos = bytes_seen;
    if (bytes_seen < jmsp_pkg::COUNT_SAT) bytes_seen++;
    if (eoi_pair_seen && eoi_pair_age < jmsp_pkg::AGE_SAT) eoi_pair_age++;
    if (last_was_ff && b == jmsp_pkg::BYTE_EOI) begin
      eoi_pair_seen = 1'b1;
      eoi_pair_age  = 8'd1;
    end
    last_was_ff = (pos >= jmsp_pkg::PAIR_START) && (b == jmsp_pkg::BYTE_FILL);
    if (!verdict_held) begin
      // A file that ends right where a segment should start counts as cut short.
      if (is_final && stream_phase == jmsp_pkg::PH_MARK) hold_verdict(jmsp_pkg::VERDICT_TRUNC);
      else walk_markers(b);
    end
    if (is_final) begin
      if (bytes_seen < jmsp_pkg::COUNT_MIN) v = jmsp_pkg::VERDICT_NOTJPEG;
      else if (verdict_held) v = held_verdict;
      else if (!scan_started) v = jmsp_pkg::VERDICT_TRUNC;
      else if (eoi_pair_seen && eoi_pair_age < eoi_window_cfg) v = jmsp_pkg::VERDICT_OK;
      else v = jmsp_pkg::VERDICT_TRUNC;
      expected_verdicts.push_back(v);
      clear_file_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_final);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.is_last   <= is_final;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b, is_final);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Stops the input and waits until every verdict has come back and the block is quiet.
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [7:0] w);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    eoi_window_cfg = w;
  endtask

  task automatic build_file(input flaw_t flaw);
    int          n_seg, flaw_slot, s, n, tail;
    logic [7:0]  m;
    logic [15:0] seg_len;
    file_bytes.delete();
    if (flaw == FLAW_TINY || flaw == FLAW_NOISE) begin
      n = (flaw == FLAW_TINY) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
      if (flaw == FLAW_NOISE && $urandom_range(0, 1) == 1) begin
        file_bytes[0] = jmsp_pkg::BYTE_FILL;
        file_bytes[1] = jmsp_pkg::BYTE_SOI;
      end
      return;
    end
    file_bytes.push_back(jmsp_pkg::BYTE_FILL);
    file_bytes.push_back(jmsp_pkg::BYTE_SOI);
    n_seg = $urandom_range(0, 2);
    flaw_slot = $urandom_range(0, n_seg);
    for (s = 0; s <= n_seg; s++) begin
      if (s == flaw_slot) begin
        case (flaw)
          FLAW_PROG: begin
            file_bytes.push_back(jmsp_pkg::BYTE_FILL);
            file_bytes.push_back(jmsp_pkg::BYTE_PROG);
          end
          FLAW_VARIANT: begin
            case ($urandom_range(0, 3))
              0: m = MARK_SOF3;
              1: m = 8'($urandom_range(MARK_SOF5, MARK_SOF7));
              2: m = MARK_DAC;
              default: m = 8'($urandom_range(MARK_SOF9, MARK_SOF15));
            endcase
            file_bytes.push_back(jmsp_pkg::BYTE_FILL);
            file_bytes.push_back(m);
          end
          FLAW_SHORT_LEN: begin
            file_bytes.push_back(jmsp_pkg::BYTE_FILL);
            file_bytes.push_back(MARK_APP0);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'($urandom_range(0, 1)));
          end
          FLAW_NO_MARK: file_bytes.push_back(8'($urandom_range(0, 254)));
          FLAW_EARLY_EOI: begin
            file_bytes.push_back(jmsp_pkg::BYTE_FILL);
            file_bytes.push_back(jmsp_pkg::BYTE_EOI);
          end
          default: ;
        endcase
      end
      if (s == n_seg) break;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) file_bytes.push_back(jmsp_pkg::BYTE_FILL);
      end
      file_bytes.push_back(jmsp_pkg::BYTE_FILL);
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 3))
          0: file_bytes.push_back(jmsp_pkg::BYTE_TEM);
          1: file_bytes.push_back(jmsp_pkg::BYTE_SOI);
          default: file_bytes.push_back(jmsp_pkg::BYTE_RST0 + 8'($urandom_range(0, 7)));
        endcase
      end else begin
        case ($urandom_range(0, 7))
          0: m = MARK_SOF0;
          1: m = MARK_SOF1;
          2: m = MARK_DHT;
          3: m = MARK_DQT;
          4: m = MARK_DRI;
          5: m = MARK_APP0 + 8'($urandom_range(0, 15));
          6: m = MARK_COM;
          default: m = 8'($urandom_range(MARK_PLAIN_LO, MARK_PLAIN_HI));
        endcase
        file_bytes.push_back(m);
        // Short segments only; one directed file carries a segment longer than 255 bytes.
        n = $urandom_range(0, 4);
        seg_len = 16'(n + 2);
        file_bytes.push_back(seg_len[15:8]);
        file_bytes.push_back(seg_len[7:0]);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    file_bytes.push_back(jmsp_pkg::BYTE_FILL);
    file_bytes.push_back(jmsp_pkg::BYTE_SOS);
    repeat ($urandom_range(0, 6)) begin
      m = 8'($urandom_range(0, 255));
      file_bytes.push_back(m);
      if (m == jmsp_pkg::BYTE_FILL) begin
        if ($urandom_range(0, 3) == 0) begin
          file_bytes.push_back(jmsp_pkg::BYTE_RST0 + 8'($urandom_range(0, 7)));
        end else begin
          file_bytes.push_back(BYTE_STUFF);
        end
      end
    end
    if (flaw != FLAW_NO_EOI) begin
      file_bytes.push_back(jmsp_pkg::BYTE_FILL);
      file_bytes.push_back(jmsp_pkg::BYTE_EOI);
    end
    // Trailing bytes: a short random tail, or a tail placed around the edge of the search window.
    case ($urandom_range(0, 9))
      0, 1, 2, 3: tail = $urandom_range(0, 3);
      4: tail = int'(eoi_window_cfg) - 2;
      5: tail = int'(eoi_window_cfg) - 1;
      6: tail = int'(eoi_window_cfg);
      7: tail = $urandom_range(0, 20);
      default: tail = 0;
    endcase
    if (tail < 0) tail = 0;
    repeat (tail) file_bytes.push_back(8'($urandom_range(0, 255)));
    if (flaw == FLAW_CUT) begin
      n = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
    end
  endtask

  task automatic send_random_file();
    int    r;
    flaw_t flaw;
    r = $urandom_range(0, 99);
    if (r < 50) flaw = FLAW_NONE;
    else if (r < 58) flaw = FLAW_CUT;
    else if (r < 63) flaw = FLAW_PROG;
    else if (r < 68) flaw = FLAW_VARIANT;
    else if (r < 73) flaw = FLAW_SHORT_LEN;
    else if (r < 78) flaw = FLAW_NO_MARK;
    else if (r < 83) flaw = FLAW_EARLY_EOI;
    else if (r < 89) flaw = FLAW_NO_EOI;
    else if (r < 95) flaw = FLAW_NOISE;
    else flaw = FLAW_TINY;
    build_file(flaw);
    send_file();
  endtask

  task automatic test_directed_verdicts();
    idle_enabled = 1'b0;
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL,
                   jmsp_pkg::BYTE_SOS, jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_EOI};
    send_file();
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL,
                   jmsp_pkg::BYTE_PROG};
    send_file();
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL, MARK_SOF3};
    send_file();
    file_bytes = '{BYTE_STUFF};
    send_file();
    // An end-of-image marker before any scan ends the parse early.
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL,
                   jmsp_pkg::BYTE_EOI};
    send_file();
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL, MARK_APP0,
                   8'h00, 8'h01};
    send_file();
    // A 256-byte segment holding a pair that has aged up to the saturation point by the end.
    file_bytes = '{jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_SOI, jmsp_pkg::BYTE_FILL, MARK_APP0,
                   8'h01, 8'h00, jmsp_pkg::BYTE_FILL, jmsp_pkg::BYTE_EOI};
    repeat (252) file_bytes.push_back(BYTE_STUFF);
    file_bytes.push_back(jmsp_pkg::BYTE_FILL);
    file_bytes.push_back(jmsp_pkg::BYTE_SOS);
    file_bytes.push_back(BYTE_STUFF);
    file_bytes.push_back(BYTE_STUFF);
    send_file();
  endtask

  task automatic test_window_register();
    logic [7:0] windows[4];
    int         i;
    windows = '{8'd2, 8'd0, 8'd1, 8'($urandom_range(3, 12))};
    idle_enabled = 1'b1;
    for (i = 0; i < 4; i++) begin
      write_window(windows[i]);
      repeat (2) begin
        build_file(($urandom_range(0, 4) == 0) ? FLAW_NO_EOI : FLAW_NONE);
        send_file();
      end
    end
  endtask

  task automatic test_random_files(input int n_files);
    repeat (n_files) begin
      idle_enabled = ($urandom_range(0, 3) != 0);
      send_random_file();
    end
  endtask

  task automatic test_sender_waits_for_verdicts();
    idle_enabled = 1'b1;
    repeat (3) begin
      send_random_file();
      settle_block();
    end
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    repeat (4) send_random_file();
  endtask

  // Result side: random stalls on ready and a check of every verdict word taken.
  always @(posedge clk) begin : verdict_check
    jmsp_pkg::verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("verdict: expected none, actual %0d", out_if.verdict);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.verdict !== want) begin
          $error("verdict: expected %0d, actual %0d", want, out_if.verdict);
          fail_count++;
        end
      end
    end
    if (rx_hold == 0) rx_hold = idle_gap();
    if (rx_hold != 0) begin
      rx_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.is_last   = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    eoi_window_cfg  = jmsp_pkg::EOI_WINDOW_RESET;
    clear_file_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_verdicts();
    test_window_register();
    test_random_files(6);
    test_sender_waits_for_verdicts();
    test_back_to_back();
    write_window(jmsp_pkg::EOI_WINDOW_RESET);
    test_random_files(2);

    settle_block();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
